// ----- src/biquad_cascade_equalizer_macros.svh -----
// ============================================================================
// biquad_cascade_equalizer_macros.svh - assertion helpers
// Clocked, reset-qualified assertion wrappers for the equalizer RTL.
// ============================================================================
`ifndef BIQUAD_CASCADE_EQUALIZER_MACROS_SVH
`define BIQUAD_CASCADE_EQUALIZER_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define BQE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define BQE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bqe_pkg.sv -----
// ============================================================================
// bqe_pkg - equalizer shared definitions
// Field widths, fixed-point formats, operation and register codes.
// ============================================================================
package bqe_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int CH_W     = 2;
    localparam int BAND_W   = 3;
    localparam int IDX_W    = 3;
    localparam int SAMPLE_W = 24;      // Q1.23
    localparam int COEF_W   = 32;      // Q6.26
    localparam int GAIN_W   = 16;      // unsigned Q4.12
    localparam int STATE_W  = 40;      // internal signal and delays

    localparam int COEF_FRAC  = COEF_W - 6;
    localparam int GAIN_FRAC  = 12;
    localparam int COEF_TERMS = 5;

    // multiplier splits the state operand into two halves
    localparam int HALF_W = STATE_W / 2;
    localparam int PART_W = HALF_W + 1;
    localparam int PROD_W = COEF_W + PART_W;
    localparam int ACC_W  = COEF_W + STATE_W + 2;

    // operations
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // coefficient slots within a band
    localparam logic [IDX_W-1:0] K_B0 = 3'd0;
    localparam logic [IDX_W-1:0] K_B1 = 3'd1;
    localparam logic [IDX_W-1:0] K_B2 = 3'd2;
    localparam logic [IDX_W-1:0] K_A1 = 3'd3;
    localparam logic [IDX_W-1:0] K_A2 = 3'd4;

    // configuration registers
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
    localparam logic [COEF_W-1:0] COEF_ONE =
        {{(COEF_W-COEF_FRAC-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};

    typedef struct packed {
        logic issue;    // product enters the pipe
        logic clr;      // start a new sum
        logic sub;      // subtract the product
        logic hi;       // upper half of the state operand
    } t_mac_op;

endpackage

// ----- src/biquad_cascade_equalizer.sv -----
// ============================================================================
// biquad_cascade_equalizer - multi-channel five-band parametric EQ
// Cascaded TDF-II biquads per channel, linear post gain, 24-bit saturation.
// ============================================================================
// Usage:
//  s_axis carries one request per beat; tuser = operation. Process requests
//  return one result on m_axis; coefficient writes and clears return none.
//  Coefficient write and clear finish on acceptance and s_axis_tready stays high.
//  A filtered sample runs each band through its read, product and write-back
//  steps on one shared MAC (each 40-bit state operand goes through the 32x21
//  multiplier in two halves), then through the post gain steps into the
//  output register; the next request is taken once that result is loaded.
//  Bypass (enable off, or channel not below CHANNELS): the sample goes to the
//  output register unchanged, and the next request is taken once it is loaded.
//  The result sits in an output register; while m_axis_tready is low the
//  block still takes the next request and holds its own result back until
//  the register frees.
//  cfg port: index 0 enable, index 1 post gain (Q4.12); always ready, write
//  only while no sample is in flight.
//  Reset: enable off, unity gain, all coefficients pass-through (b0 = 1),
//  all delays zero; valid bits cover both memories, so no clearing pass.
// ============================================================================
`include "biquad_cascade_equalizer_macros.svh"

module biquad_cascade_equalizer #(
    parameter int BANDS    = 5,
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // channel[1:0], sample_in[25:2], band[28:26],
                                        // coef_index[31:29], coef_value[63:32]
    input  logic [bqe_pkg::OP_W-1:0] s_axis_tuser,   // operation[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sample_out[23:0], channel_out[25:24],
                                        // clipped[26], zero[31:27]
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [bqe_pkg::GAIN_W-1:0] i_cfg_data
);
    import bqe_pkg::*;

    localparam int CDEPTH = BANDS * COEF_TERMS;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int DDEPTH = CHANNELS * BANDS;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int BCW    = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int DW     = 2 * STATE_W;

    // top-level states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BAND = 2'd1;
    localparam logic [1:0] S_GAIN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // band steps: L/H are the low and high half of one product
    localparam logic [3:0] ST_RD    = 4'd0;
    localparam logic [3:0] ST_B0L   = 4'd1;
    localparam logic [3:0] ST_B0H   = 4'd2;
    localparam logic [3:0] ST_B1L   = 4'd3;
    localparam logic [3:0] ST_B1H   = 4'd4;   // y ready
    localparam logic [3:0] ST_A1L   = 4'd5;
    localparam logic [3:0] ST_A1H   = 4'd6;
    localparam logic [3:0] ST_B2L   = 4'd7;
    localparam logic [3:0] ST_B2H   = 4'd8;   // z1 ready
    localparam logic [3:0] ST_A2L   = 4'd9;
    localparam logic [3:0] ST_A2H   = 4'd10;
    localparam logic [3:0] ST_DRAIN = 4'd11;
    localparam logic [3:0] ST_Z2    = 4'd12;  // z2 ready, write back
    // gain steps
    localparam logic [3:0] ST_GLO   = 4'd0;
    localparam logic [3:0] ST_GHI   = 4'd1;
    localparam logic [3:0] ST_GDRN  = 4'd2;

    // request fields
    logic [OP_W-1:0]            w_op;
    logic [CH_W-1:0]            w_ch;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic [BAND_W-1:0]          w_band;
    logic [IDX_W-1:0]           w_idx;
    logic [COEF_W-1:0]          w_coef;

    assign w_ch     = s_axis_tdata[1:0];
    assign w_sample = s_axis_tdata[25:2];
    assign w_band   = s_axis_tdata[28:26];
    assign w_idx    = s_axis_tdata[31:29];
    assign w_coef   = s_axis_tdata[63:32];
    assign w_op     = s_axis_tuser;

    // control
    logic [1:0]     r_state, n_state;
    logic [3:0]     r_step, n_step;
    logic [BCW-1:0] r_band;
    logic [CAW-1:0] r_cbase;
    logic [DAW-1:0] r_daddr;
    logic           r_enable;
    logic [GAIN_W-1:0] r_gain;
    logic           r_ovalid;

    // datapath
    logic signed [STATE_W-1:0]  r_x, r_y, r_z1old, r_z2old, r_z1new;
    logic [CH_W-1:0]            r_ch;
    logic                       r_pass;
    logic [SAMPLE_W-1:0]        r_osample;
    logic [CH_W-1:0]            r_och;
    logic                       r_oclip;

    logic w_in_acc, w_filt, w_last, w_out_load, w_band_end;

    // memories
    logic              w_c_we, w_c_re;
    logic [CAW-1:0]    w_c_waddr, w_c_raddr;
    logic [IDX_W-1:0]  w_c_k;
    logic [COEF_W-1:0] w_c_dflt, w_c_rdata;
    logic              w_d_we, w_d_re, w_d_clr;
    logic [DW-1:0]     w_d_rdata;

    // MAC
    t_mac_op                   w_mop;
    logic                      w_use_y;
    logic signed [COEF_W-1:0]  w_mcoef;
    logic signed [STATE_W-1:0] w_mx, w_addend, w_state_val;
    logic signed [SAMPLE_W-1:0] w_gain_val;
    logic                      w_clip;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_filt        = r_enable && (32'(w_ch) < CHANNELS);
    assign w_last        = (r_band == BCW'(BANDS - 1));
    assign w_band_end    = (r_state == S_BAND) && (r_step == ST_Z2);
    assign w_out_load    = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_op == OP_SAMPLE)) begin
                    n_step  = ST_RD;
                    n_state = w_filt ? S_BAND : S_OUT;
                end
            end
            S_BAND: begin
                if (r_step == ST_Z2) begin
                    n_step = ST_RD;
                    if (w_last) begin
                        n_step  = ST_GLO;
                        n_state = S_GAIN;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_GAIN: begin
                if (r_step == ST_GDRN) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_RD;
            r_band   <= '0;
            r_cbase  <= '0;
            r_daddr  <= '0;
            r_enable <= 1'b0;
            r_gain   <= GAIN_UNITY;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;

            if (w_in_acc && (w_op == OP_SAMPLE)) begin
                r_band  <= '0;
                r_cbase <= '0;
                r_daddr <= DAW'(w_ch * BANDS);
            end else if (w_band_end && !w_last) begin
                r_band  <= r_band + BCW'(1);
                r_cbase <= r_cbase + CAW'(COEF_TERMS);
                r_daddr <= r_daddr + DAW'(1);
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_GAIN:   r_gain   <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_op == OP_SAMPLE)) begin
            r_x    <= STATE_W'(w_sample);
            r_ch   <= w_ch;
            r_pass <= !w_filt;
        end
        if (r_state == S_BAND) begin
            case (r_step)
                ST_B0L: begin
                    r_z1old <= w_d_rdata[STATE_W-1:0];
                    r_z2old <= w_d_rdata[DW-1:STATE_W];
                end
                ST_B1H:  r_y     <= w_state_val;
                ST_B2H:  r_z1new <= w_state_val;
                ST_Z2:   r_x     <= r_y;          // band output feeds next band
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_osample <= r_pass ? r_x[SAMPLE_W-1:0] : w_gain_val;
            r_och     <= r_ch;
            r_oclip   <= !r_pass && w_clip;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oclip, r_och, r_osample};

    // ------------------------------------------------------ coefficient memory
    // Row per band: b0 b1 b2 a1 a2. Read in the step before the product.
    always_comb begin
        w_c_re = 1'b0;
        w_c_k  = K_B0;
        if (r_state == S_BAND) begin
            case (r_step)
                ST_RD:   begin w_c_re = 1'b1; w_c_k = K_B0; end
                ST_B0H:  begin w_c_re = 1'b1; w_c_k = K_B1; end
                ST_B1H:  begin w_c_re = 1'b1; w_c_k = K_A1; end
                ST_A1H:  begin w_c_re = 1'b1; w_c_k = K_B2; end
                ST_B2H:  begin w_c_re = 1'b1; w_c_k = K_A2; end
                default: ;
            endcase
        end
    end

    assign w_c_raddr = r_cbase + CAW'(w_c_k);
    assign w_c_dflt  = (w_c_k == K_B0) ? COEF_ONE : '0;   // pass-through until written
    assign w_c_we    = w_in_acc && (w_op == OP_COEF) && (32'(w_band) < BANDS)
                       && (32'(w_idx) < COEF_TERMS);
    assign w_c_waddr = CAW'(w_band * COEF_TERMS + w_idx);

    bqe_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH),
        .AW    (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (1'b0),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_coef),
        .i_re    (w_c_re),
        .i_raddr (w_c_raddr),
        .i_rdflt (w_c_dflt),
        .o_rdata (w_c_rdata)
    );

    // ------------------------------------------------------------ delay memory
    // Entry per channel and band: {z2, z1}. Read at band start, written back
    // at band end; entries of one sample never overlap.
    assign w_d_re  = (r_state == S_BAND) && (r_step == ST_RD);
    assign w_d_we  = w_band_end;
    assign w_d_clr = w_in_acc && (w_op == OP_CLEAR);

    bqe_ram #(
        .WIDTH (DW),
        .DEPTH (DDEPTH),
        .AW    (DAW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_d_clr),
        .i_we    (w_d_we),
        .i_waddr (r_daddr),
        .i_wdata ({w_state_val, r_z1new}),
        .i_re    (w_d_re),
        .i_raddr (r_daddr),
        .i_rdflt ('0),
        .o_rdata (w_d_rdata)
    );

    // --------------------------------------------------------------------- MAC
    // y  = b0*x + z1;  z1' = b1*x - a1*y + z2;  z2' = b2*x - a2*y
    always_comb begin
        w_mop    = '0;
        w_use_y  = 1'b0;
        w_addend = '0;
        if (r_state == S_BAND) begin
            case (r_step)
                ST_B0L: begin w_mop.issue = 1'b1; w_mop.clr = 1'b1; end
                ST_B0H: begin w_mop.issue = 1'b1; w_mop.hi  = 1'b1; end
                ST_B1L: begin w_mop.issue = 1'b1; w_mop.clr = 1'b1; end
                ST_B1H: begin
                    w_mop.issue = 1'b1;
                    w_mop.hi    = 1'b1;
                    w_addend    = r_z1old;
                end
                ST_A1L: begin w_mop.issue = 1'b1; w_mop.sub = 1'b1; w_use_y = 1'b1; end
                ST_A1H: begin
                    w_mop.issue = 1'b1;
                    w_mop.sub   = 1'b1;
                    w_mop.hi    = 1'b1;
                    w_use_y     = 1'b1;
                end
                ST_B2L: begin w_mop.issue = 1'b1; w_mop.clr = 1'b1; end
                ST_B2H: begin
                    w_mop.issue = 1'b1;
                    w_mop.hi    = 1'b1;
                    w_addend    = r_z2old;
                end
                ST_A2L: begin w_mop.issue = 1'b1; w_mop.sub = 1'b1; w_use_y = 1'b1; end
                ST_A2H: begin
                    w_mop.issue = 1'b1;
                    w_mop.sub   = 1'b1;
                    w_mop.hi    = 1'b1;
                    w_use_y     = 1'b1;
                end
                default: ;
            endcase
        end else if (r_state == S_GAIN) begin
            case (r_step)
                ST_GLO:  begin w_mop.issue = 1'b1; w_mop.clr = 1'b1; end
                ST_GHI:  begin w_mop.issue = 1'b1; w_mop.hi  = 1'b1; end
                default: ;
            endcase
        end
    end

    assign w_mcoef = (r_state == S_GAIN) ? COEF_W'(r_gain) : w_c_rdata;
    assign w_mx    = w_use_y ? r_y : r_x;

    bqe_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_mop),
        .i_coef   (w_mcoef),
        .i_x      (w_mx),
        .i_addend (w_addend),
        .o_state  (w_state_val),
        .o_sample (w_gain_val),
        .o_clip   (w_clip)
    );

    // -------------------------------------------------------------- assertions
    `BQE_ASSERT_NXT(a_sample_leaves_idle,
        w_in_acc && (w_op == OP_SAMPLE), r_state != S_IDLE,
        "process request did not start work")
    `BQE_ASSERT_NXT(a_gain_after_last_band,
        w_band_end && w_last, (r_state == S_GAIN) && (r_step == ST_GLO),
        "post gain did not follow the last band")
    `BQE_ASSERT_NXT(a_result_waits_on_stall,
        (r_state == S_OUT) && m_axis_tvalid && !m_axis_tready, r_state == S_OUT,
        "result overran a stalled output register")
    `BQE_ASSERT_IMP(a_band_in_range,
        r_state == S_BAND, 32'(r_band) < BANDS,
        "band counter out of range")

endmodule

// ----- src/bqe_ram.sv -----
// ============================================================================
// bqe_ram - synchronous RAM with per-entry valid bits
// One write port, one registered read port; unwritten entries read as a
// caller-supplied default. Clear drops every valid bit at once.
// ============================================================================
module bqe_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic [WIDTH-1:0] i_rdflt,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             r_rvalid;
    logic [WIDTH-1:0] r_rdata;
    logic [WIDTH-1:0] r_rdflt;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
            r_rdflt <= i_rdflt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : r_rdflt;

endmodule

// ----- src/bqe_mac.sv -----
// ============================================================================
// bqe_mac - shared multiply-accumulate unit
// 32x21 multiplier, product register, exact accumulator, and the floor
// shift plus saturation back to state and sample widths.
// ============================================================================
module bqe_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bqe_pkg::t_mac_op                     i_op,
    input  logic signed [bqe_pkg::COEF_W-1:0]    i_coef,
    input  logic signed [bqe_pkg::STATE_W-1:0]   i_x,
    input  logic signed [bqe_pkg::STATE_W-1:0]   i_addend,
    output logic signed [bqe_pkg::STATE_W-1:0]   o_state,
    output logic signed [bqe_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                 o_clip
);
    import bqe_pkg::*;

    localparam int SHC_W = ACC_W - COEF_FRAC;
    localparam int SUM_W = SHC_W + 1;
    localparam int SHG_W = ACC_W - GAIN_FRAC;

    logic signed [PART_W-1:0] w_part;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    t_mac_op                  r_op;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SHC_W-1:0]  w_shc;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SHG_W-1:0]  w_shg;
    logic                     w_st_ovf;

    // low half is unsigned, high half carries the sign
    assign w_part = i_op.hi ? {i_x[STATE_W-1], i_x[STATE_W-1 -: HALF_W]}
                            : {1'b0, i_x[HALF_W-1:0]};
    assign w_prod = i_coef * w_part;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_op.issue) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
    end

    assign w_term = r_op.hi ? (ACC_W'(r_prod) <<< HALF_W) : ACC_W'(r_prod);
    assign n_acc  = (r_op.clr ? ACC_W'(0) : r_acc) + (r_op.sub ? -w_term : w_term);

    // floor shift, add delay term, clamp to state width
    assign w_shc    = r_acc[ACC_W-1:COEF_FRAC];
    assign w_sum    = SUM_W'(w_shc) + SUM_W'(i_addend);
    assign w_st_ovf = (w_sum[SUM_W-1:STATE_W-1] != '0) && (w_sum[SUM_W-1:STATE_W-1] != '1);

    always_comb begin
        if (!w_st_ovf) begin
            o_state = w_sum[STATE_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            o_state = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            o_state = {1'b0, {(STATE_W-1){1'b1}}};
        end
    end

    // post gain: floor by gain fraction, clamp to sample width
    assign w_shg  = r_acc[ACC_W-1:GAIN_FRAC];
    assign o_clip = (w_shg[SHG_W-1:SAMPLE_W-1] != '0) && (w_shg[SHG_W-1:SAMPLE_W-1] != '1);

    always_comb begin
        if (!o_clip) begin
            o_sample = w_shg[SAMPLE_W-1:0];
        end else if (w_shg[SHG_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule
